>>> rtl/core/ipv4_fragment_header_generator_unit_assert.svh
// Assertion macros shared by the checker of the fragment header generator.
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_UNIT_ASSERT_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define IFHG_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fragment header generator: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define IFHG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fragment header generator: next-cycle check failed");

`endif

>>> rtl/core/ifhg_pkg.sv
// Package with types and constants of the IPv4 fragment header generator.
`timescale 1ns / 1ps
package ifhg_pkg;

   localparam logic [15:0] MaxPayload   = 16'd65515;
   localparam logic [7:0]  MinUnits     = 8'd128;
   localparam logic [7:0]  MaxUnits     = 8'd185;
   localparam logic [31:0] SourceReset  = 32'd0;
   localparam logic [7:0]  UnitsReset   = 8'd185;
   localparam logic [7:0]  TtlReset     = 8'd64;
   localparam logic [15:0] IdReset      = 16'hFFFF;
   // Version/IHL word plus the 20 header bytes that every total length carries.
   localparam logic [15:0] HeaderConst  = 16'h4514;
   localparam logic [15:0] HeaderBytes  = 16'd20;

   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrSourceAddress = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrChunkUnits    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrTimeToLive    = 2'd2;

   localparam int ReqDataWidth = 56;
   localparam int RspDataWidth = 128;

   typedef struct packed {
      logic load;  // capture a request
      logic prep;  // form the per-datagram checksum base
      logic emit;  // produce one fragment into the output register
   } ifhg_cmd_type;

   typedef struct packed {
      logic more;  // the fragment now being formed is not the last one
   } ifhg_stat_type;

   typedef struct packed {
      logic [10:0] slice_length;
      logic [15:0] slice_start;
      logic [15:0] header_checksum;
      logic [31:0] destination_out;
      logic [7:0]  protocol_out;
      logic [12:0] offset_units;
      logic        more_fragments;
      logic [15:0] identification;
      logic [10:0] total_length;
   } ifhg_frag_type;

endpackage

>>> rtl/core/ifhg_ctrl.sv
// Controller state machine that sequences capture, setup and fragment output.
`timescale 1ns / 1ps
module ifhg_ctrl
   import ifhg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  ifhg_stat_type stat,
   output ifhg_cmd_type  cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_EMIT} state_type;

   state_type state_ff;
   logic      out_valid_ff;
   logic      slot_free;

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_tvalid;
      cmd.prep = (state_ff == ST_PREP);
      cmd.emit = (state_ff == ST_EMIT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (slot_free && !stat.more) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/ifhg_dp.sv
// Datapath: configuration registers, datagram context, fragment walk and checksum.
`timescale 1ns / 1ps
module ifhg_dp
   import ifhg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic [15:0]              payload_length,
   input  logic [31:0]              destination_address,
   input  logic [7:0]               protocol_number,
   input  ifhg_cmd_type             cmd,
   output ifhg_stat_type            stat,
   output ifhg_frag_type            frag
);

   logic [31:0] source_ff;
   logic [7:0]  units_ff;
   logic [7:0]  ttl_ff;
   logic [15:0] id_ff;

   logic [15:0] dst_hi_ff;
   logic [15:0] dst_lo_ff;
   logic [7:0]  proto_ff;
   logic [10:0] chunk_ff;
   logic [15:0] pos_ff;
   logic [15:0] remain_ff;
   logic [18:0] base_ff;
   ifhg_frag_type frag_ff;

   logic [15:0] len_in;
   logic [7:0]  units_in;
   logic [18:0] base_in;
   logic        more;
   logic [10:0] slice;
   logic [15:0] flagoff;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      len_in = (payload_length > MaxPayload) ? MaxPayload : payload_length;
      if (units_ff < MinUnits) begin
         units_in = MinUnits;
      end else if (units_ff > MaxUnits) begin
         units_in = MaxUnits;
      end else begin
         units_in = units_ff;
      end
      base_in = 19'(HeaderConst) + 19'(id_ff) + 19'({ttl_ff, proto_ff})
              + 19'(source_ff[31:16]) + 19'(source_ff[15:0])
              + 19'(dst_hi_ff) + 19'(dst_lo_ff);
   end

   // Per-fragment header terms; the fixed words were summed once into base_ff.
   always_comb begin
      more    = remain_ff > 16'(chunk_ff);
      slice   = more ? chunk_ff : remain_ff[10:0];
      flagoff = {2'b00, more, pos_ff[15:3]};
      sum     = 20'(base_ff) + 20'(slice) + 20'(flagoff);
      fold1   = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2   = fold1[15:0] + 16'(fold1[16]);
   end

   assign stat.more = more;
   assign frag      = frag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= SourceReset;
         units_ff  <= UnitsReset;
         ttl_ff    <= TtlReset;
         id_ff     <= IdReset;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrSourceAddress: source_ff <= csr_wdata;
               CsrChunkUnits:    units_ff  <= csr_wdata[7:0];
               CsrTimeToLive:    ttl_ff    <= csr_wdata[7:0];
               default:          ;
            endcase
         end
         if (cmd.load) begin
            id_ff <= id_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dst_hi_ff <= destination_address[31:16];
         dst_lo_ff <= destination_address[15:0];
         proto_ff  <= protocol_number;
         chunk_ff  <= {units_in, 3'b000};
         pos_ff    <= 16'd0;
         remain_ff <= len_in;
      end
      if (cmd.prep) begin
         base_ff <= base_in;
      end
      if (cmd.emit) begin
         frag_ff.total_length    <= 11'(HeaderBytes) + slice;
         frag_ff.identification  <= id_ff;
         frag_ff.more_fragments  <= more;
         frag_ff.offset_units    <= pos_ff[15:3];
         frag_ff.protocol_out    <= proto_ff;
         frag_ff.destination_out <= {dst_hi_ff, dst_lo_ff};
         frag_ff.header_checksum <= ~fold2;
         frag_ff.slice_start     <= pos_ff;
         frag_ff.slice_length    <= slice;
         pos_ff    <= pos_ff + 16'(chunk_ff);
         remain_ff <= remain_ff - 16'(chunk_ff);
      end
   end

endmodule

>>> rtl/core/ipv4_fragment_header_generator_unit.sv
// Top level of the IPv4 fragment header generator.
//
// Request channel (req_*): one transaction per outgoing datagram, carrying the
// payload length, destination address and protocol number. Response channel
// (rsp_*): one transaction per fragment header, in order of increasing offset;
// rsp_tlast marks the final fragment of the datagram. The csr_* port writes the
// source address, chunk size and TTL; write it only while no datagram is open.
// Each accepted request advances a 16-bit identification counter that resets
// to all ones, so the first datagram after reset carries identification 0.
// After a request is accepted, the controller passes through its setup state,
// where the checksum base is formed, to its output state. Fragments follow one
// per cycle while rsp_tready stays high; a datagram has 1 to 64 fragments, and
// the per-fragment walk runs in the controller's output state.
// The next request is taken as soon as the last fragment sits in the output
// register, even if it has not yet been taken. When the receiver stalls, the
// output register holds its transaction and the fragment walk pauses.
// Reset is synchronous: it restores the register defaults and the counter
// and drops any open datagram and pending response.
`timescale 1ns / 1ps
module ipv4_fragment_header_generator_unit
   import ifhg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // payload_length, destination_address, protocol_number
   input  logic [ReqDataWidth-1:0]  req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // total_length, identification, more_fragments, offset_units, protocol_out,
   // destination_out, header_checksum, slice_start, slice_length, zero pad
   output logic [RspDataWidth-1:0]  rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_wdata
);

   ifhg_cmd_type  cmd;
   ifhg_stat_type stat;
   ifhg_frag_type frag;

   ifhg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ifhg_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .payload_length      (req_tdata[15:0]),
      .destination_address (req_tdata[47:16]),
      .protocol_number     (req_tdata[55:48]),
      .cmd                 (cmd),
      .stat                (stat),
      .frag                (frag)
   );

   assign rsp_tdata = {4'b0000, frag.slice_length, frag.slice_start,
                       frag.header_checksum, frag.destination_out, frag.protocol_out,
                       frag.offset_units, frag.more_fragments, frag.identification,
                       frag.total_length};
   assign rsp_tlast = !frag.more_fragments;

endmodule

>>> rtl/core/ifhg_checker.sv
// Port-level checker for the fragment header generator, with its bind.
`timescale 1ns / 1ps
`include "ipv4_fragment_header_generator_unit_assert.svh"
module ifhg_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast
);

   // A stalled response transaction stays put.
   `IFHG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // Total length is always the header plus the slice carried.
   `IFHG_ASSERT_SAME(a_tlen_sum, clock, reset, rsp_tvalid, rsp_tdata[10:0] == rsp_tdata[123:113] + 11'd20)
   // The MF flag is set exactly on fragments that are not the last one.
   `IFHG_ASSERT_SAME(a_mf_last, clock, reset, rsp_tvalid, rsp_tdata[27] != rsp_tlast)
   // A fragment that is followed by more carries a whole number of 8-byte units.
   `IFHG_ASSERT_SAME(a_mid_align, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[115:113] == 3'd0 && rsp_tdata[123:113] >= 11'd1024)
   // Nothing is presented at the first edge after reset is released.
   `IFHG_ASSERT_SAME(a_reset_quiet, clock, reset, $fell(reset), !rsp_tvalid)

endmodule

bind ipv4_fragment_header_generator_unit ifhg_checker u_ifhg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> bench/ipv4_fragment_header_generator_unit_tb.sv
// Self-checking testbench of the IPv4 fragment header generator, with its own header predictor.
`timescale 1ns / 1ps
module ipv4_fragment_header_generator_unit_tb;
   import ifhg_pkg::*;

   localparam int CycleLimit    = 1_000_000;
   localparam int SettleCycles  = 6;
   localparam int NumPhases     = 8;
   localparam int ItemsPerPhase = 32;
   localparam int MaxPrinted    = 40;
   localparam logic [15:0] VersionIhlTos = 16'h4500;

   typedef struct packed {
      logic          last;
      ifhg_frag_type hdr;
   } frag_expect_type;

   typedef struct {
      logic [15:0]     len;
      logic [31:0]     dst;
      logic [7:0]      proto;
      bit              typed;
      frag_expect_type want;
   } datagram_row_type;

   typedef enum int {ReadyAlways, ReadyCoin, ReadyScarce, ReadyEveryThird} ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // payload_length, destination_address, protocol_number
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // total_length, identification, more_fragments, offset_units, protocol_out,
   // destination_out, header_checksum, slice_start, slice_length, zero pad
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CsrSourceAddress;
   logic [31:0]              csr_wdata = '0;

   // Predictor copy of the registers and the identification counter.
   logic [31:0] model_source      = SourceReset;
   logic [7:0]  model_chunk_units = UnitsReset;
   logic [7:0]  model_ttl         = TtlReset;
   logic [15:0] model_ident       = IdReset;

   frag_expect_type  pending_headers[$];
   datagram_row_type directed_rows[$];

   int             error_count = 0;
   int             cycle_count = 0;
   int             datagrams_sent = 0;
   int             headers_checked = 0;
   int             max_frags = 0;
   int             burst_left = 0;
   int             ready_left = 0;
   int             ready_tick = 0;
   ready_mode_type ready_mode = ReadyAlways;

   ipv4_fragment_header_generator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MaxPrinted) begin
         $display("[%0t] header %0d: %s", $time, headers_checked, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic int effective_chunk_bytes();
      int units;
      units = model_chunk_units;
      if (units < MinUnits) units = MinUnits;
      if (units > MaxUnits) units = MaxUnits;
      return units * 8;
   endfunction

   function automatic logic [15:0] ipv4_header_checksum(input logic [10:0] tlen,
                                                        input logic [15:0] ident,
                                                        input logic [15:0] flag_offset,
                                                        input logic [7:0]  proto,
                                                        input logic [31:0] dst);
      logic [15:0] words [9];
      logic [16:0] acc;
      words = '{VersionIhlTos, {5'b0, tlen}, ident, flag_offset, {model_ttl, proto},
                model_source[31:16], model_source[15:0], dst[31:16], dst[15:0]};
      acc = '0;
      // End-around carry after every word keeps the sum within 16 bits.
      foreach (words[i]) begin
         acc = {1'b0, acc[15:0]} + words[i];
         acc = {1'b0, acc[15:0]} + acc[16];
      end
      return ~acc[15:0];
   endfunction

   task automatic predict_fragments(input logic [15:0] req_len, input logic [31:0] dst,
                                    input logic [7:0] proto);
      logic [15:0]     len;
      logic [15:0]     chunk;
      logic [15:0]     pos;
      logic [15:0]     remain;
      logic [15:0]     slice;
      logic            more;
      frag_expect_type e;
      int              n;
      len = (req_len > MaxPayload) ? MaxPayload : req_len;
      chunk = 16'(effective_chunk_bytes());
      model_ident = model_ident + 16'd1;
      pos = '0;
      n = 0;
      do begin
         remain = len - pos;
         more = remain > chunk;
         slice = more ? chunk : remain;
         e.last = !more;
         e.hdr.total_length = 11'(slice + HeaderBytes);
         e.hdr.identification = model_ident;
         e.hdr.more_fragments = more;
         e.hdr.offset_units = pos[15:3];
         e.hdr.protocol_out = proto;
         e.hdr.destination_out = dst;
         e.hdr.header_checksum = ipv4_header_checksum(e.hdr.total_length, model_ident,
                                                      {2'b00, more, pos[15:3]}, proto, dst);
         e.hdr.slice_start = pos;
         e.hdr.slice_length = slice[10:0];
         pending_headers.push_back(e);
         pos = pos + chunk;
         n++;
      end while (more && n < 64);
      if (n > max_frags) max_frags = n;
   endtask

   function automatic logic [15:0] pick_payload_length();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, 3000);
         // Near whole multiples of the chunk, where the last fragment is full or tiny.
         4, 5: v = $urandom_range(1, 6) * effective_chunk_bytes() + $urandom_range(0, 2) - 1;
         6: v = $urandom_range(65400, 65535);
         default: v = $urandom_range(0, 65535);
      endcase
      return 16'(v);
   endfunction

   task automatic add_row(input logic [15:0] len, input logic [31:0] dst, input logic [7:0] proto,
                          input bit typed, input frag_expect_type want);
      datagram_row_type r;
      r.len = len;
      r.dst = dst;
      r.proto = proto;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endtask

   task automatic send_datagram(input logic [15:0] len, input logic [31:0] dst,
                                input logic [7:0] proto, input bit typed,
                                input frag_expect_type want);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {proto, dst, len};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (typed) begin
         pending_headers.push_back(want);
         // The typed row still consumes one identification value.
         model_ident = model_ident + 16'd1;
      end else begin
         predict_fragments(len, dst, proto);
      end
      datagrams_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 7);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic park_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_pending();
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CsrSourceAddress: model_source = data;
         CsrChunkUnits:    model_chunk_units = data[7:0];
         CsrTimeToLive:    model_ttl = data[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] src, input logic [7:0] units, input logic [7:0] ttl);
      write_register(CsrTimeToLive, {24'b0, ttl});
      write_register(CsrSourceAddress, src);
      write_register(CsrChunkUnits, {24'b0, units});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(negedge clock) begin : receiver_pattern
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(10, 150);
      end
      ready_left--;
      ready_tick++;
      case (ready_mode)
         ReadyAlways:  rsp_tready <= 1'b1;
         ReadyCoin:    rsp_tready <= 1'($urandom_range(0, 1));
         ReadyScarce:  rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (ready_tick % 3 == 0);
      endcase
   end

   always @(posedge clock) begin : header_checker
      ifhg_frag_type   got;
      frag_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = ifhg_frag_type'(rsp_tdata[$bits(ifhg_frag_type)-1:0]);
         if (pending_headers.size() == 0) begin
            report_mismatch($sformatf("transaction with nothing expected, tdata 0x%h", rsp_tdata));
         end else begin
            want = pending_headers.pop_front();
            check_field("total_length", got.total_length, want.hdr.total_length);
            check_field("identification", got.identification, want.hdr.identification);
            check_field("more_fragments", got.more_fragments, want.hdr.more_fragments);
            check_field("offset_units", got.offset_units, want.hdr.offset_units);
            check_field("protocol_out", got.protocol_out, want.hdr.protocol_out);
            check_field("destination_out", got.destination_out, want.hdr.destination_out);
            check_field("header_checksum", got.header_checksum, want.hdr.header_checksum);
            check_field("slice_start", got.slice_start, want.hdr.slice_start);
            check_field("slice_length", got.slice_length, want.hdr.slice_length);
            check_field("last_fragment", rsp_tlast, want.last);
         end
         headers_checked++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d headers outstanding.",
                  cycle_count, pending_headers.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0]     phase_source [NumPhases];
      logic [7:0]      phase_units  [NumPhases];
      logic [7:0]      phase_ttl    [NumPhases];
      frag_expect_type row_want;

      phase_source = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0A00_0001, 32'hC0A8_0001,
                       32'h1234_5678, 32'h0, 32'h0, 32'h0};
      phase_units  = '{8'd128, 8'd185, 8'd0, 8'd255, 8'd127, 8'd186, 8'd0, 8'd0};
      phase_ttl    = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd64, 8'd0, 8'd0, 8'd0};

      // First datagram after reset: identification 0, and the end-around sum is
      // all ones, so the checksum comes out as zero.
      row_want.last = 1'b1;
      row_want.hdr = '{slice_length: 11'd0, slice_start: 16'd0, header_checksum: 16'h0000,
                       destination_out: 32'h0000_7AEB, protocol_out: 8'h00, offset_units: 13'd0,
                       more_fragments: 1'b0, identification: 16'd0, total_length: 11'd20};
      add_row(16'd0, 32'h0000_7AEB, 8'h00, 1'b1, row_want);
      // A payload of exactly one default chunk is not fragmented.
      row_want.hdr = '{slice_length: 11'd1480, slice_start: 16'd0, header_checksum: 16'h7423,
                       destination_out: 32'hFFFF_FFFF, protocol_out: 8'hFF, offset_units: 13'd0,
                       more_fragments: 1'b0, identification: 16'd1, total_length: 11'd1500};
      add_row(16'd1480, 32'hFFFF_FFFF, 8'hFF, 1'b1, row_want);
      add_row(16'd1,     32'h0000_0000, 8'h00, 1'b0, '0);
      add_row(16'd1481,  32'h5555_5555, 8'hAA, 1'b0, '0);
      add_row(16'd1479,  32'hAAAA_AAAA, 8'h55, 1'b0, '0);
      add_row(16'd2960,  32'h0102_0304, 8'd6,  1'b0, '0);
      add_row(16'd65515, 32'hC0A8_0A01, 8'd17, 1'b0, '0);
      add_row(16'd65516, 32'h7F00_0001, 8'd1,  1'b0, '0);
      add_row(16'd65535, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0);
      add_row(16'h5555,  32'h0000_0000, 8'h01, 1'b0, '0);
      add_row(16'hAAAA,  32'h8000_0001, 8'h80, 1'b0, '0);
      add_row(16'd8,     32'h0000_0001, 8'h7F, 1'b0, '0);
      add_row(16'd7,     32'hFFFF_FFFE, 8'hFE, 1'b0, '0);
      add_row(16'd0,     32'hFFFF_FFFF, 8'hFF, 1'b0, '0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_datagram(directed_rows[i].len, directed_rows[i].dst, directed_rows[i].proto,
                       directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         if (phase >= 5) begin
            phase_source[phase] = $urandom();
            phase_ttl[phase] = 8'($urandom_range(0, 255));
         end
         if (phase >= 6) begin
            phase_units[phase] = 8'($urandom_range(0, 255));
         end
         // Registers may only change once the block has gone quiet.
         park_requests();
         drain_pending();
         configure(phase_source[phase], phase_units[phase], phase_ttl[phase]);
         repeat (ItemsPerPhase) begin
            send_datagram(pick_payload_length(), $urandom(), 8'($urandom_range(0, 255)),
                          1'b0, '0);
         end
      end

      park_requests();
      drain_pending();

      $display("Sent %0d datagrams, checked %0d fragment headers, up to %0d per datagram.",
               datagrams_sent, headers_checked, max_frags);
      $display("Covered %0d register settings, clamped chunk sizes and oversize payloads.",
               NumPhases + 1);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
